>>> rtl/core/trd_pkg.sv
`default_nettype none

package trd_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_BYTES_PER_PIXEL = 2'd2
    } trd_cfg_idx_t;

    localparam logic [2:0] BPP_WIDE    = 3'd4;
    localparam logic [2:0] BPP_RESET   = 3'd3;
    localparam logic [1:0] HOLD_CYCLES = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    typedef struct packed {
        logic                      we;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } trd_cfg_wr_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       last;
        logic       status;
    } trd_pix_t;

endpackage

`default_nettype wire

>>> rtl/core/trd_front.sv
`default_nettype none

module trd_front #(
    parameter int PIXEL_COUNT_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trd_pkg::trd_cfg_wr_t cfg_wr,
    input  logic                 in_fire,
    input  logic [7:0]           data_byte,
    output logic                 hold,
    output logic                 push,
    output trd_pkg::trd_pix_t    result
);
    import trd_pkg::*;

    localparam int          PB  = PIXEL_COUNT_BITS;
    localparam int          SW  = (PB + 1 > 9) ? PB + 1 : 9;
    localparam logic [32:0] CAP = (33'd1 << PB) - 33'd1;

    logic [15:0]   width_reg;
    logic [15:0]   height_reg;
    logic [2:0]    bpp_reg;
    logic [1:0]    hold_cnt_reg;
    logic [31:0]   product_reg;
    logic [PB-1:0] total_reg;

    logic          expecting_reg, expecting_next;
    logic          run_reg, run_next;
    logic [7:0]    pkt_left_reg, pkt_left_next;
    logic [1:0]    pos_reg, pos_next;
    logic [7:0]    colour_reg [3];
    logic [7:0]    colour_next [3];
    logic [PB-1:0] done_reg, done_next;

    logic          bpp_wide;
    logic          final_byte;
    logic [7:0]    hdr_count;
    logic          overflow;
    logic [7:0]    rep_raw;
    logic [7:0]    rep;
    logic [7:0]    left_after;
    logic [SW-1:0] pix_done_sum;
    logic          image_end;

    // configuration registers and image size pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 16'd1;
            height_reg   <= 16'd1;
            bpp_reg      <= BPP_RESET;
            hold_cnt_reg <= '0;
            product_reg  <= 32'd1;
            total_reg    <= PB'(1);
        end
        else
        begin
            if (cfg_wr.we)
            begin
                case (cfg_wr.index)
                    CFG_IMAGE_WIDTH:     width_reg  <= cfg_wr.data;
                    CFG_IMAGE_HEIGHT:    height_reg <= cfg_wr.data;
                    CFG_BYTES_PER_PIXEL: bpp_reg    <= cfg_wr.data[2:0];
                    default:             ;
                endcase
            end
            if (cfg_wr.we)
            begin
                hold_cnt_reg <= HOLD_CYCLES;
            end
            else if (hold_cnt_reg != 2'd0)
            begin
                hold_cnt_reg <= hold_cnt_reg - 2'd1;
            end
            product_reg <= 32'(width_reg) * 32'(height_reg);
            total_reg   <= ({1'b0, product_reg} > CAP) ? CAP[PB-1:0] : product_reg[PB-1:0];
        end
    end

    assign hold = (hold_cnt_reg != 2'd0);

    assign bpp_wide   = (bpp_reg == BPP_WIDE);
    assign final_byte = bpp_wide ? (pos_reg == 2'd3) : (pos_reg >= 2'd2);
    // header low seven bits plus one covers both raw and run packets
    assign hdr_count  = {1'b0, data_byte[6:0]} + 8'd1;
    assign overflow   = (SW'(done_reg) + SW'(hdr_count)) > SW'(total_reg);

    assign rep_raw      = run_reg ? pkt_left_reg : 8'd1;
    assign rep          = (rep_raw > pkt_left_reg) ? pkt_left_reg : rep_raw;
    assign left_after   = pkt_left_reg - rep;
    assign pix_done_sum = SW'(done_reg) + SW'(rep);
    assign image_end    = (pix_done_sum >= SW'(total_reg));

    always_comb
    begin
        expecting_next = expecting_reg;
        run_next       = run_reg;
        pkt_left_next  = pkt_left_reg;
        pos_next       = pos_reg;
        colour_next    = colour_reg;
        done_next      = done_reg;
        push           = 1'b0;
        result         = '0;

        if (in_fire)
        begin
            if (expecting_reg)
            begin
                if (overflow)
                begin
                    push           = 1'b1;
                    result.last    = 1'b1;
                    result.status  = STATUS_OVERFLOW;
                    expecting_next = 1'b1;
                    run_next       = 1'b0;
                    pkt_left_next  = 8'd0;
                    pos_next       = 2'd0;
                    colour_next    = '{default: 8'd0};
                    done_next      = '0;
                end
                else
                begin
                    run_next       = data_byte[7];
                    pkt_left_next  = hdr_count;
                    pos_next       = 2'd0;
                    expecting_next = 1'b0;
                end
            end
            else if (!final_byte)
            begin
                if (pos_reg != 2'd3)
                begin
                    colour_next[pos_reg] = data_byte;
                end
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                push              = 1'b1;
                result.blue       = colour_reg[0];
                result.green      = colour_reg[1];
                result.red        = bpp_wide ? colour_reg[2] : data_byte;
                result.alpha      = bpp_wide ? data_byte : 8'd0;
                result.repeat_res = rep;
                result.last       = image_end;
                result.status     = STATUS_OK;
                pkt_left_next     = left_after;
                pos_next          = 2'd0;
                if (left_after == 8'd0)
                begin
                    expecting_next = 1'b1;
                end
                if (image_end)
                begin
                    expecting_next = 1'b1;
                    run_next       = 1'b0;
                    pkt_left_next  = 8'd0;
                    colour_next    = '{default: 8'd0};
                    done_next      = '0;
                end
                else
                begin
                    done_next = pix_done_sum[PB-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expecting_reg <= 1'b1;
            run_reg       <= 1'b0;
            pkt_left_reg  <= 8'd0;
            pos_reg       <= 2'd0;
            colour_reg    <= '{default: 8'd0};
            done_reg      <= '0;
        end
        else
        begin
            expecting_reg <= expecting_next;
            run_reg       <= run_next;
            pkt_left_reg  <= pkt_left_next;
            pos_reg       <= pos_next;
            colour_reg    <= colour_next;
            done_reg      <= done_next;
        end
    end

`ifndef SYNTHESIS
    // an overflow word restarts the image
    a_overflow_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        push && result.status |=> expecting_reg && (done_reg == '0))
        else $error("overflow did not restart image");
`endif

endmodule

`default_nettype wire

>>> rtl/core/trd_fifo.sv
`default_nettype none

module trd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  trd_pkg::trd_pix_t wr_data,
    input  logic              pop,
    output trd_pkg::trd_pix_t rd_data,
    output logic              full,
    output logic              empty
);
    import trd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    trd_pix_t      entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/trd_back.sv
`default_nettype none

module trd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fifo_empty,
    input  trd_pkg::trd_pix_t fifo_data,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output trd_pkg::trd_pix_t out_data
);
    import trd_pkg::*;

    logic     valid_reg, valid_next;
    trd_pix_t data_reg;

    // refill the output register whenever it is free or being drained
    assign pop = !fifo_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= fifo_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/core/tga_rle_pixel_decoder.sv
`default_nettype none

// Run-length coded true-color pixel decoder. Feed the packet bytes that follow
// the 18-byte file header, one byte per input word. A packet header below 128
// announces header+1 raw pixels, 128 or more one pixel repeated header-127
// times. Color bytes arrive blue, green, red (, alpha when bytes_per_pixel is
// 4; any other value means 3). Each raw pixel comes out as one word with
// repeat_res 1, and a run comes out as one word carrying its full count. The
// word that completes width*height pixels has last set; a packet header that
// asks for more pixels than remain gives one all-zero word with last and
// status set. Either way the decoder then waits for the first header of a new
// image. Rate: one input byte per cycle while in_ready is high, at most one
// output word per byte; the parser settles each byte combinationally and a
// two-entry queue plus the output register keep it running while the sink
// stalls, until the queue fills. An output word passes through the queue and
// then the output register. Register writes (index 0 width, 1 height, 2 bytes
// per pixel) are taken at once, but in_ready stays low after each write while
// the registered width*height product and its saturation settle. Write
// registers only while no words are in flight.
module tga_rle_pixel_decoder #(
    parameter int PIXEL_COUNT_BITS = 32,
    parameter int QUEUE_DEPTH      = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [trd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [trd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         data_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [7:0]                         alpha,
    output logic [7:0]                         repeat_res,
    output logic                               last,
    output logic                               status
);
    import trd_pkg::*;

    trd_cfg_wr_t cfg_wr;
    logic        front_hold;
    logic        push;
    trd_pix_t    front_word;
    trd_pix_t    queue_word;
    trd_pix_t    out_word;
    logic        queue_full;
    logic        queue_empty;
    logic        pop;
    logic        in_fire;

    // register writes never stall
    assign cfg_ready    = 1'b1;
    assign cfg_wr.we    = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // every byte makes at most one word, so one free queue slot is enough
    assign in_ready = !queue_full && !front_hold;
    assign in_fire  = in_valid && in_ready;

    trd_front #(
        .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .in_fire  (in_fire),
        .data_byte(data_byte),
        .hold     (front_hold),
        .push     (push),
        .result   (front_word)
    );

    trd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_data(front_word),
        .pop    (pop),
        .rd_data(queue_word),
        .full   (queue_full),
        .empty  (queue_empty)
    );

    trd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_empty(queue_empty),
        .fifo_data (queue_word),
        .pop       (pop),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_word)
    );

    assign red        = out_word.red;
    assign green      = out_word.green;
    assign blue       = out_word.blue;
    assign alpha      = out_word.alpha;
    assign repeat_res = out_word.repeat_res;
    assign last       = out_word.last;
    assign status     = out_word.status;

`ifndef SYNTHESIS
    // size pipeline must hold off input right after a register write
    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input accepted while image size settles");

    // overflow word is all zero and closes the image
    a_overflow_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OVERFLOW) |->
            last && (repeat_res == 8'd0) && (red == 8'd0) && (green == 8'd0)
            && (blue == 8'd0) && (alpha == 8'd0))
        else $error("malformed overflow word");

    // a pixel word always covers at least one pixel
    a_pixel_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OK) |-> (repeat_res != 8'd0))
        else $error("pixel word with zero count");
`endif

endmodule

`default_nettype wire
